// ===== hw/rtl/pfcs_pkg.sv =====
// ----------------------------------------------------------------------------
// Folder command sequencer package
// Shared constants, frame types and the frame builder used by the sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

package pfcs_pkg;

    localparam int NUM_FOLDERS = 4;
    localparam int MAX_RESULTS = 6;

    localparam logic [7:0] MUTE_CODE  = 8'd99;
    localparam logic [4:0] VOL_MAX    = 5'd30;
    localparam logic [2:0] EQ_MAX     = 3'd4;
    localparam logic [7:0] START_BYTE = 8'hAA;

    localparam logic [7:0] CMD_FOLDER_UP   = 8'h0F;
    localparam logic [7:0] CMD_FOLDER_DOWN = 8'h0E;
    localparam logic [7:0] CMD_SHUFFLE     = 8'h18;
    localparam logic [7:0] CMD_START_TRACK = 8'h02;
    localparam logic [7:0] CMD_VOLUME      = 8'h13;
    localparam logic [7:0] CMD_SELECT_SD   = 8'h0B;
    localparam logic [7:0] CMD_EQ          = 8'h1A;
    localparam logic [7:0] CMD_NEXT        = 8'h06;

    localparam logic [1:0] LAST_STEP = 2'(MAX_RESULTS - 4);

    localparam logic [1:0] CFG_ONLINE = 2'd0;
    localparam logic [1:0] CFG_VOLUME = 2'd1;
    localparam logic [1:0] CFG_EQ     = 2'd2;

    localparam logic [1:0] REQ_TICK  = 2'd0;
    localparam logic [1:0] REQ_NEXT  = 2'd1;
    localparam logic [1:0] REQ_SETUP = 2'd2;

    typedef enum logic [3:0] {
        K_UP     = 4'd0,
        K_DOWN   = 4'd1,
        K_MUTE   = 4'd2,
        K_RANDOM = 4'd3,
        K_VOLUME = 4'd4,
        K_PLAY   = 4'd5,
        K_NEXT   = 4'd6,
        K_SD     = 4'd7,
        K_EQ     = 4'd8
    } t_frame_kind;

    typedef struct packed {
        logic [2:0] len;
        logic [7:0] b4;
        logic [7:0] b3;
        logic [7:0] b2;
        logic [7:0] b1;
        logic [7:0] b0;
    } t_frame;

    typedef struct packed {
        logic        emit;
        t_frame_kind kind;
        logic        last;
        logic        load_tick;
        logic        set_done;
        logic        setup_start;
    } t_dp_cmd;

    typedef struct packed {
        logic online;
        logic tick_skip;
        logic want_mute;
        logic at_target;
        logic next_at_target;
        logic dir_up;
        logic muted;
        logic out_free;
    } t_dp_status;

    function automatic t_frame frame4(input logic [7:0] code, input logic [7:0] b3);
        t_frame f;
        f.b0  = START_BYTE;
        f.b1  = code;
        f.b2  = 8'h00;
        f.b3  = b3;
        f.b4  = 8'h00;
        f.len = 3'd4;
        return f;
    endfunction

    function automatic t_frame frame5(input logic [7:0] code, input logic [7:0] payload);
        t_frame f;
        f.b0  = START_BYTE;
        f.b1  = code;
        f.b2  = 8'h01;
        f.b3  = payload;
        f.b4  = START_BYTE + code + 8'h01 + payload;
        f.len = 3'd5;
        return f;
    endfunction

    function automatic t_frame build_frame(input t_frame_kind kind,
                                           input logic [4:0] vol,
                                           input logic [2:0] eq);
        logic [4:0] vol_sat;
        logic [2:0] eq_ok;
        t_frame     f;
        vol_sat = (vol > VOL_MAX) ? VOL_MAX : vol;
        eq_ok   = (eq > EQ_MAX) ? 3'd0 : eq;
        case (kind)
            K_UP:     f = frame4(CMD_FOLDER_UP, 8'hB9);
            K_DOWN:   f = frame4(CMD_FOLDER_DOWN, 8'hB8);
            K_MUTE:   f = frame5(CMD_VOLUME, 8'h00);
            K_RANDOM: f = frame5(CMD_SHUFFLE, 8'h05);
            K_VOLUME: f = frame5(CMD_VOLUME, {3'b000, vol_sat});
            K_PLAY:   f = frame4(CMD_START_TRACK, 8'hAC);
            K_NEXT:   f = frame4(CMD_NEXT, 8'hB0);
            K_SD:     f = frame5(CMD_SELECT_SD, 8'h01);
            K_EQ:     f = frame5(CMD_EQ, {5'b00000, eq_ok});
            default:  f = frame4(CMD_START_TRACK, 8'hAC);
        endcase
        return f;
    endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/player_folder_command_sequencer_unit.sv =====
// ----------------------------------------------------------------------------
// Player folder command sequencer
// Turns tick, next-track and setup requests into audio module command frames.
//
// Channel   Dir  Handshake                    Payload
// s_axis    in   s_axis_tvalid/s_axis_tready  tdata: desired_folder; tuser: req_type
// m_axis    out  m_axis_tvalid/m_axis_tready  tdata: frame bytes, length; tlast
// cfg       in   i_cfg_we                     i_cfg_idx, i_cfg_data
//
// A request yields one frame per cycle while m_axis does not stall, up to
// six frames; a tick first passes through a decision state. The controller
// state machine sets the frame order, and a stall on m_axis holds it in place.
// New requests are taken only when the sequence of the last one is issued.
// Reset is synchronous and active low.
// ----------------------------------------------------------------------------
`default_nettype none

module player_folder_command_sequencer_unit
    import pfcs_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,  // [7:0] desired_folder
    input  wire logic [1:0]  s_axis_tuser,  // [1:0] req_type
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // [7:0] frame_byte0, [15:8] frame_byte1, [23:16] frame_byte2,
    // [31:24] frame_byte3, [39:32] frame_byte4, [42:40] frame_length
    output logic [47:0]      m_axis_tdata,
    output logic             m_axis_tlast,
    input  wire logic        i_cfg_we,
    input  wire logic [1:0]  i_cfg_idx,
    input  wire logic [4:0]  i_cfg_data
);

    t_dp_cmd    cmd;
    t_dp_status status;
    t_frame     frame;

    pfcs_controller u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (s_axis_tvalid),
        .i_req_type  (s_axis_tuser),
        .o_req_ready (s_axis_tready),
        .i_status    (status),
        .o_cmd       (cmd)
    );

    pfcs_datapath u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_desired   (s_axis_tdata),
        .i_cmd       (cmd),
        .o_status    (status),
        .o_out_valid (m_axis_tvalid),
        .o_frame     (frame),
        .o_out_last  (m_axis_tlast),
        .i_out_ready (m_axis_tready)
    );

    assign m_axis_tdata = {5'b00000, frame};

`ifndef SYNTH
    a_emit_only_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.emit |-> status.out_free)
        else $error("frame issued while output register was still full");

    a_last_returns_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (cmd.emit && cmd.last) |=> s_axis_tready)
        else $error("sequencer did not return to idle after final frame");

    a_more_frames_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (cmd.emit && !cmd.last) |=> !s_axis_tready)
        else $error("sequencer took a request in the middle of a sequence");

    a_short_frame_pad: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && (m_axis_tdata[42:40] == 3'd4)) |-> (m_axis_tdata[39:32] == 8'h00))
        else $error("four-byte frame carries a nonzero fifth byte");
`endif

endmodule

`default_nettype wire

// ===== hw/rtl/pfcs_datapath.sv =====
// ----------------------------------------------------------------------------
// Folder command sequencer datapath
// Holds configuration, folder tracking state and the output frame register.
// ----------------------------------------------------------------------------
`default_nettype none

module pfcs_datapath
    import pfcs_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic [1:0]  i_cfg_idx,
    input  wire logic [4:0]  i_cfg_data,
    input  wire logic [7:0]  i_desired,
    input  wire t_dp_cmd     i_cmd,
    output t_dp_status       o_status,
    output logic             o_out_valid,
    output t_frame           o_frame,
    output logic             o_out_last,
    input  wire logic        i_out_ready
);

    logic       r_online;
    logic [4:0] r_volume;
    logic [2:0] r_eq;
    logic [2:0] r_cur;
    logic [7:0] r_last_desired;
    logic       r_done;
    logic       r_muted;
    logic       r_valid;
    t_frame     r_frame;
    logic       r_last;

    logic [7:0] want_in;
    logic [7:0] cur_ext;
    logic [7:0] cur_inc;
    logic [7:0] cur_dec;
    logic       dir_up;
    logic       out_free;

    assign want_in = (((i_desired >= 8'd1) && (i_desired <= 8'(NUM_FOLDERS)))
                      || (i_desired == MUTE_CODE)) ? i_desired : 8'd1;
    assign cur_ext = {5'b00000, r_cur};
    assign cur_inc = {5'b00000, r_cur + 3'd1};
    assign cur_dec = {5'b00000, r_cur - 3'd1};
    assign dir_up  = r_last_desired > cur_ext;
    assign out_free = !r_valid || i_out_ready;

    always_comb begin
        o_status.online         = r_online;
        o_status.tick_skip      = (want_in == r_last_desired) && r_done;
        o_status.want_mute      = r_last_desired == MUTE_CODE;
        o_status.at_target      = r_last_desired == cur_ext;
        o_status.next_at_target = dir_up ? (r_last_desired == cur_inc)
                                         : (r_last_desired == cur_dec);
        o_status.dir_up         = dir_up;
        o_status.muted          = r_muted;
        o_status.out_free       = out_free;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_online <= 1'b0;
            r_volume <= 5'd30;
            r_eq     <= 3'd1;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_ONLINE: r_online <= i_cfg_data[0];
                CFG_VOLUME: r_volume <= i_cfg_data;
                CFG_EQ:     r_eq     <= i_cfg_data[2:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur          <= 3'd1;
            r_last_desired <= 8'hFF;
            r_done         <= 1'b0;
            r_muted        <= 1'b0;
        end else begin
            if (i_cmd.load_tick && (want_in != r_last_desired)) begin
                r_last_desired <= want_in;
                r_done         <= 1'b0;
            end
            if (i_cmd.set_done) begin
                r_done <= 1'b1;
            end
            if (i_cmd.setup_start) begin
                r_muted <= 1'b0;
            end
            if (i_cmd.emit) begin
                case (i_cmd.kind)
                    K_UP:     r_cur   <= r_cur + 3'd1;
                    K_DOWN:   r_cur   <= r_cur - 3'd1;
                    K_MUTE:   r_muted <= 1'b1;
                    K_VOLUME: r_muted <= 1'b0;
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_frame <= build_frame(i_cmd.kind, r_volume, r_eq);
            r_last  <= i_cmd.last;
        end
    end

    assign o_out_valid = r_valid;
    assign o_frame     = r_frame;
    assign o_out_last  = r_last;

endmodule

`default_nettype wire

// ===== hw/rtl/pfcs_controller.sv =====
// ----------------------------------------------------------------------------
// Folder command sequencer controller
// Walks the frame sequence of each request and drives the datapath commands.
// ----------------------------------------------------------------------------
`default_nettype none

module pfcs_controller
    import pfcs_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_req_valid,
    input  wire logic [1:0]  i_req_type,
    output logic             o_req_ready,
    input  wire t_dp_status  i_status,
    output t_dp_cmd          o_cmd
);

    typedef enum logic [12:0] {
        S_IDLE    = 13'b0000000000001,
        S_TICK    = 13'b0000000000010,
        S_STEP    = 13'b0000000000100,
        S_MUTE    = 13'b0000000001000,
        S_RANDOM  = 13'b0000000010000,
        S_UNMUTE  = 13'b0000000100000,
        S_PLAY    = 13'b0000001000000,
        S_NEXT    = 13'b0000010000000,
        S_SD      = 13'b0000100000000,
        S_VOL     = 13'b0001000000000,
        S_EQ      = 13'b0010000000000,
        S_SU_RAND = 13'b0100000000000,
        S_SU_PLAY = 13'b1000000000000
    } t_state;

    t_state     r_state;
    t_state     n_state;
    logic [1:0] r_steps;
    logic [1:0] n_steps;

    assign o_req_ready = (r_state == S_IDLE);

    always_comb begin
        n_state = r_state;
        n_steps = r_steps;
        o_cmd   = '0;
        o_cmd.kind = K_PLAY;
        case (r_state)
            S_IDLE: begin
                if (i_req_valid && i_status.online) begin
                    case (i_req_type)
                        REQ_TICK: begin
                            o_cmd.load_tick = 1'b1;
                            if (!i_status.tick_skip) begin
                                n_state = S_TICK;
                            end
                        end
                        REQ_NEXT: n_state = S_NEXT;
                        REQ_SETUP: begin
                            o_cmd.setup_start = 1'b1;
                            n_state = S_SD;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_TICK: begin
                n_steps = 2'd0;
                if (i_status.want_mute) begin
                    n_state = S_MUTE;
                end else if (i_status.at_target) begin
                    n_state = S_RANDOM;
                end else begin
                    n_state = S_STEP;
                end
            end
            S_STEP: begin
                if (i_status.out_free) begin
                    o_cmd.emit = 1'b1;
                    o_cmd.kind = i_status.dir_up ? K_UP : K_DOWN;
                    o_cmd.last = !i_status.next_at_target && (r_steps == LAST_STEP);
                    n_steps = r_steps + 2'd1;
                    if (i_status.next_at_target) begin
                        n_state = S_RANDOM;
                    end else if (r_steps == LAST_STEP) begin
                        n_state = S_IDLE;
                    end
                end
            end
            S_MUTE: begin
                if (i_status.out_free) begin
                    o_cmd.emit     = 1'b1;
                    o_cmd.kind     = K_MUTE;
                    o_cmd.last     = 1'b1;
                    o_cmd.set_done = 1'b1;
                    n_state = S_IDLE;
                end
            end
            S_RANDOM: begin
                if (i_status.out_free) begin
                    o_cmd.emit = 1'b1;
                    o_cmd.kind = K_RANDOM;
                    n_state = i_status.muted ? S_UNMUTE : S_PLAY;
                end
            end
            S_UNMUTE: begin
                if (i_status.out_free) begin
                    o_cmd.emit = 1'b1;
                    o_cmd.kind = K_VOLUME;
                    n_state = S_PLAY;
                end
            end
            S_PLAY: begin
                if (i_status.out_free) begin
                    o_cmd.emit     = 1'b1;
                    o_cmd.kind     = K_PLAY;
                    o_cmd.last     = 1'b1;
                    o_cmd.set_done = 1'b1;
                    n_state = S_IDLE;
                end
            end
            S_NEXT: begin
                if (i_status.out_free) begin
                    o_cmd.emit = 1'b1;
                    o_cmd.kind = K_NEXT;
                    o_cmd.last = 1'b1;
                    n_state = S_IDLE;
                end
            end
            S_SD: begin
                if (i_status.out_free) begin
                    o_cmd.emit = 1'b1;
                    o_cmd.kind = K_SD;
                    n_state = S_VOL;
                end
            end
            S_VOL: begin
                if (i_status.out_free) begin
                    o_cmd.emit = 1'b1;
                    o_cmd.kind = K_VOLUME;
                    n_state = S_EQ;
                end
            end
            S_EQ: begin
                if (i_status.out_free) begin
                    o_cmd.emit = 1'b1;
                    o_cmd.kind = K_EQ;
                    n_state = S_SU_RAND;
                end
            end
            S_SU_RAND: begin
                if (i_status.out_free) begin
                    o_cmd.emit = 1'b1;
                    o_cmd.kind = K_RANDOM;
                    n_state = S_SU_PLAY;
                end
            end
            S_SU_PLAY: begin
                if (i_status.out_free) begin
                    o_cmd.emit = 1'b1;
                    o_cmd.kind = K_PLAY;
                    o_cmd.last = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_steps <= 2'd0;
        end else begin
            r_state <= n_state;
            r_steps <= n_steps;
        end
    end

endmodule

`default_nettype wire

// ===== tb/tb_player_folder_command_sequencer_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Folder command sequencer testbench
// Drives tick, next-track and setup requests into the sequencer and checks
// every command frame against a predictor of the folder walk, mute handling
// and setup sequence, under several register settings and random stalls.
// ----------------------------------------------------------------------------

module tb_player_folder_command_sequencer_unit;
    import pfcs_pkg::*;

    localparam logic [1:0] REQ_UNUSED  = 2'd3;
    localparam logic [7:0] SUM_UP      = 8'hB9;
    localparam logic [7:0] SUM_DOWN    = 8'hB8;
    localparam logic [7:0] SUM_PLAY    = 8'hAC;
    localparam logic [7:0] SUM_NEXT    = 8'hB0;
    localparam logic [7:0] RANDOM_MODE = 8'h05;
    localparam logic [7:0] SD_CARD     = 8'h01;

    typedef struct packed {
        logic       last;
        logic [2:0] len;
        logic [7:0] b4;
        logic [7:0] b3;
        logic [7:0] b2;
        logic [7:0] b1;
        logic [7:0] b0;
    } t_cmd_frame;

    class t_frame_predictor;
        bit         online;
        logic [4:0] volume;
        logic [2:0] eq;
        logic [2:0] folder_now;
        logic [7:0] want_last;
        bit         done;
        bit         muted;
        int         emitted;
        int         mismatches;
        t_cmd_frame frames_due[$];

        function new();
            online     = 1'b0;
            volume     = VOL_MAX;
            eq         = 3'd1;
            folder_now = 3'd1;
            want_last  = 8'hFF;
            done       = 1'b0;
            muted      = 1'b0;
            mismatches = 0;
        endfunction

        function void write_reg(input logic [1:0] idx, input logic [4:0] data);
            case (idx)
                CFG_ONLINE: online = data[0];
                CFG_VOLUME: volume = data;
                CFG_EQ:     eq = data[2:0];
                default: ;
            endcase
        endfunction

        function void push4(input logic [7:0] code, input logic [7:0] chk);
            t_cmd_frame f;
            if (emitted >= MAX_RESULTS) return;
            f = '{last: 1'b0, len: 3'd4, b4: 8'h00, b3: chk, b2: 8'h00, b1: code,
                  b0: START_BYTE};
            frames_due.push_back(f);
            emitted++;
        endfunction

        function void push5(input logic [7:0] code, input logic [7:0] payload);
            t_cmd_frame f;
            logic [7:0] sum;
            if (emitted >= MAX_RESULTS) return;
            sum = START_BYTE + code + 8'h01 + payload;
            f = '{last: 1'b0, len: 3'd5, b4: sum, b3: payload, b2: 8'h01, b1: code,
                  b0: START_BYTE};
            frames_due.push_back(f);
            emitted++;
        endfunction

        function void push_volume(input logic [4:0] v);
            push5(CMD_VOLUME, {3'b000, (v > VOL_MAX) ? VOL_MAX : v});
        endfunction

        function void play_run();
            push5(CMD_SHUFFLE, RANDOM_MODE);
            if (muted) begin
                push_volume(volume);
                muted = 1'b0;
            end
            push4(CMD_START_TRACK, SUM_PLAY);
        endfunction

        function void tick(input logic [7:0] raw);
            logic [7:0] want;
            int         steps;
            steps = 0;
            if ((raw >= 8'd1 && raw <= 8'(NUM_FOLDERS)) || raw == MUTE_CODE) begin
                want = raw;
            end else begin
                want = 8'd1;
            end
            if (want != want_last) begin
                want_last = want;
                done = 1'b0;
            end
            if (done) return;
            if (want == MUTE_CODE) begin
                push5(CMD_VOLUME, 8'h00);
                muted = 1'b1;
                done = 1'b1;
                return;
            end
            while ({5'b0, folder_now} != want && steps < MAX_RESULTS - 3) begin
                if (want > {5'b0, folder_now}) begin
                    push4(CMD_FOLDER_UP, SUM_UP);
                    folder_now = folder_now + 3'd1;
                end else begin
                    push4(CMD_FOLDER_DOWN, SUM_DOWN);
                    folder_now = folder_now - 3'd1;
                end
                steps++;
            end
            if ({5'b0, folder_now} != want) return;
            play_run();
            done = 1'b1;
        endfunction

        function void setup();
            push5(CMD_SELECT_SD, SD_CARD);
            push_volume(volume);
            push5(CMD_EQ, {5'b00000, (eq > EQ_MAX) ? 3'd0 : eq});
            push5(CMD_SHUFFLE, RANDOM_MODE);
            push4(CMD_START_TRACK, SUM_PLAY);
            muted = 1'b0;
        endfunction

        function void note_request(input logic [1:0] kind, input logic [7:0] folder);
            emitted = 0;
            if (!online) return;
            case (kind)
                REQ_TICK:  tick(folder);
                REQ_NEXT:  push4(CMD_NEXT, SUM_NEXT);
                REQ_SETUP: setup();
                default: ;
            endcase
            if (emitted > 0) frames_due[frames_due.size() - 1].last = 1'b1;
        endfunction

        function void compare(input string name, input logic [7:0] want,
                              input logic [7:0] got);
            if (want !== got) begin
                $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
                mismatches++;
            end
        endfunction

        function void check_frame(input logic [47:0] data, input logic last);
            t_cmd_frame want;
            t_cmd_frame got;
            got = {last, data[42:0]};
            if (frames_due.size() == 0) begin
                $display("%0t: unexpected frame, expected none, actual %h", $time, got);
                mismatches++;
                return;
            end
            want = frames_due.pop_front();
            compare("frame_byte0", want.b0, got.b0);
            compare("frame_byte1", want.b1, got.b1);
            compare("frame_byte2", want.b2, got.b2);
            compare("frame_byte3", want.b3, got.b3);
            compare("frame_byte4", want.b4, got.b4);
            compare("frame_length", {5'b0, want.len}, {5'b0, got.len});
            compare("last_frame", {7'b0, want.last}, {7'b0, got.last});
        endfunction
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = 8'h00;
    logic [1:0]  s_axis_tuser = 2'b00;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [47:0] m_axis_tdata;
    logic        m_axis_tlast;
    logic        i_cfg_we = 1'b0;
    logic [1:0]  i_cfg_idx = 2'b00;
    logic [4:0]  i_cfg_data = 5'b00000;

    bit               jitter = 1'b1;
    t_frame_predictor ledger;

    player_folder_command_sequencer_unit dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    always @(negedge i_clk) begin
        m_axis_tready <= !jitter || ($urandom_range(99) >= 34);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            ledger.check_frame(m_axis_tdata, m_axis_tlast);
        end
    end

    task automatic send_request(input logic [1:0] kind, input logic [7:0] folder);
        while (jitter && $urandom_range(99) < 34) begin
            s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= kind;
        s_axis_tdata  <= folder;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        ledger.note_request(kind, folder);
        @(negedge i_clk);
    endtask

    task automatic settle();
        int waited;
        waited = 0;
        s_axis_tvalid <= 1'b0;
        while (ledger.frames_due.size() != 0 && waited < 2000) begin
            @(negedge i_clk);
            waited++;
        end
        if (ledger.frames_due.size() != 0) begin
            $display("%0t: missing frames, expected %0d more, actual 0", $time,
                     ledger.frames_due.size());
            ledger.mismatches++;
            ledger.frames_due.delete();
        end
        repeat (12) @(negedge i_clk);
    endtask

    task automatic configure(input logic online, input logic [4:0] vol,
                             input logic [2:0] eq);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= CFG_ONLINE;
        i_cfg_data <= {4'b0000, online};
        ledger.write_reg(CFG_ONLINE, {4'b0000, online});
        @(negedge i_clk);
        i_cfg_idx  <= CFG_VOLUME;
        i_cfg_data <= vol;
        ledger.write_reg(CFG_VOLUME, vol);
        @(negedge i_clk);
        i_cfg_idx  <= CFG_EQ;
        i_cfg_data <= {2'b00, eq};
        ledger.write_reg(CFG_EQ, {2'b00, eq});
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        @(negedge i_clk);
    endtask

    task automatic run_random(input int count);
        logic [1:0] kind;
        logic [7:0] folder;
        int         pick;
        repeat (count) begin
            pick = $urandom_range(19);
            if (pick < 12) kind = REQ_TICK;
            else if (pick < 15) kind = REQ_NEXT;
            else if (pick < 18) kind = REQ_SETUP;
            else kind = REQ_UNUSED;
            pick = $urandom_range(9);
            if (pick < 7) folder = 8'($urandom_range(1, NUM_FOLDERS));
            else if (pick == 7) folder = MUTE_CODE;
            else folder = 8'($urandom_range(255));
            send_request(kind, folder);
        end
        settle();
    endtask

    initial begin
        ledger = new();
        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // The block starts offline, so these requests must give nothing.
        send_request(REQ_SETUP, 8'h00);
        send_request(REQ_TICK, 8'd3);
        send_request(REQ_NEXT, 8'h00);
        settle();

        configure(1'b1, 5'd31, 3'd5);
        send_request(REQ_SETUP, 8'hFF);
        send_request(REQ_TICK, 8'd4);
        send_request(REQ_TICK, 8'd4);
        send_request(REQ_TICK, MUTE_CODE);
        send_request(REQ_TICK, MUTE_CODE);
        send_request(REQ_TICK, 8'd0);
        send_request(REQ_TICK, 8'hFF);
        send_request(REQ_NEXT, 8'h55);
        send_request(REQ_TICK, 8'd2);
        send_request(REQ_TICK, 8'd5);
        send_request(REQ_TICK, 8'd3);
        send_request(REQ_TICK, MUTE_CODE);
        send_request(REQ_TICK, 8'd3);
        send_request(REQ_UNUSED, 8'hFF);
        send_request(REQ_SETUP, 8'hAA);
        send_request(REQ_TICK, 8'h80);
        send_request(REQ_TICK, 8'd2);
        send_request(REQ_TICK, 8'd100);
        send_request(REQ_TICK, 8'd98);
        send_request(REQ_TICK, 8'd4);
        settle();

        configure(1'b1, 5'd0, 3'd0);
        run_random(25);

        jitter = 1'b0;
        configure(1'b1, 5'd30, 3'd4);
        run_random(25);
        jitter = 1'b1;

        configure(1'b0, 5'd17, 3'd7);
        run_random(10);

        configure(1'b1, 5'd31, 3'd7);
        run_random(25);

        configure(1'b1, 5'($urandom_range(31)), 3'($urandom_range(7)));
        run_random(25);

        if (ledger.mismatches == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("status: fail");
        $finish;
    end

endmodule
